// ===== src/acs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acs_pkg
// Shared codes and reset values for the adsorption cycle sequencer.
// ----------------------------------------------------------------------------
package acs_pkg;

    localparam int NumValvesDef = 6;
    localparam int NumPumpsDef  = 3;

    localparam int PhaseW = 4;
    localparam int TimeW  = 32;
    localparam int CfgIdxW = 2;

    typedef logic [PhaseW-1:0]  t_phase;
    typedef logic [TimeW-1:0]   t_time;
    typedef logic [CfgIdxW-1:0] t_cfg_idx;

    localparam t_phase PH_INIT   = 4'd0;
    localparam t_phase PH_PRESS  = 4'd1;
    localparam t_phase PH_RD_IN  = 4'd2;
    localparam t_phase PH_CHECK  = 4'd3;
    localparam t_phase PH_ADSORB = 4'd4;
    localparam t_phase PH_RD_OUT = 4'd5;
    localparam t_phase PH_CLEAN  = 4'd6;
    localparam t_phase PH_DONE   = 4'd7;
    localparam t_phase PH_FAULT  = 4'd8;

    localparam t_cfg_idx REG_PRESS_TIMEOUT = 2'd0;
    localparam t_cfg_idx REG_ADSORB_TIME   = 2'd1;
    localparam t_cfg_idx REG_CLEAN_TIME    = 2'd2;

    localparam t_time PRESS_TIMEOUT_RST = 32'd600000;
    localparam t_time ADSORB_TIME_RST   = 32'd60000;
    localparam t_time CLEAN_TIME_RST    = 32'd120000;

    localparam logic ACT_TICK    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

endpackage
`default_nettype wire

// ===== src/adsorption_cycle_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adsorption_cycle_sequencer
// Pressure-swing adsorption cycle sequencer with valve and pump outputs.
// ----------------------------------------------------------------------------
// Takes one word per clock cycle. Each accepted tick or restart handles one
// state of the cycle in a single combinational pass and the result word
// appears in the output register on the next cycle; the only thing that
// holds off a new word is a full output register whose word is not taken in
// that same cycle. Configuration writes are taken in any cycle and should be
// issued only while no result is outstanding.
// ----------------------------------------------------------------------------
module adsorption_cycle_sequencer
#(
    parameter int NUM_VALVES = acs_pkg::NumValvesDef,
    parameter int NUM_PUMPS  = acs_pkg::NumPumpsDef
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    // configuration write channel
    input  wire                        i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire  acs_pkg::t_cfg_idx    i_cfg_index,
    input  wire  acs_pkg::t_time       i_cfg_data,
    // input channel
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire                        i_action,
    input  wire  acs_pkg::t_time       i_now_ms,
    input  wire                        i_pressure_ready,
    // result channel
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output logic [3:0]                 o_state_code,
    output logic [NUM_VALVES-1:0]      o_valves_open,
    output logic [NUM_PUMPS-1:0]       o_pumps_on,
    output logic                       o_in_fault,
    output logic                       o_state_changed
);
    import acs_pkg::*;

    typedef logic [NUM_VALVES-1:0] t_valves;
    typedef logic [NUM_PUMPS-1:0]  t_pumps;

    localparam t_valves V2 = t_valves'(1) << 1;
    localparam t_valves V3 = t_valves'(1) << 2;
    localparam t_valves V4 = t_valves'(1) << 3;
    localparam t_valves V6 = t_valves'(1) << 5;
    localparam t_pumps  P1 = t_pumps'(1);
    localparam t_pumps  P2 = t_pumps'(1) << 1;
    localparam t_pumps  P3 = t_pumps'(1) << 2;

    t_time   r_press_timeout, r_adsorb_time, r_clean_time;
    t_phase  r_phase, n_phase;
    t_time   r_start, n_start;
    logic    r_pend, n_pend;
    t_valves r_valves, n_valves;
    t_pumps  r_pumps, n_pumps;
    logic    n_changed;
    t_time   elapsed;

    logic    r_out_valid;
    t_phase  r_o_state;
    t_valves r_o_valves;
    t_pumps  r_o_pumps;
    logic    r_o_fault;
    logic    r_o_changed;

    logic    in_acc;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign elapsed     = i_now_ms - r_start;

    // one state handled per word
    always_comb begin
        logic go;
        t_phase go_to;
        go       = 1'b0;
        go_to    = r_phase;
        n_pend   = r_pend;
        n_valves = r_valves;
        n_pumps  = r_pumps;
        if (i_action == ACT_RESTART) begin
            go    = 1'b1;
            go_to = PH_INIT;
        end else begin
            case (r_phase)
                PH_PRESS: begin
                    if (r_pend) begin
                        n_valves = '0;
                        n_pumps  = r_pumps | P1;
                    end
                    go    = 1'b1;
                    go_to = PH_RD_IN;
                end
                PH_RD_IN: begin
                    go    = 1'b1;
                    go_to = PH_CHECK;
                end
                PH_CHECK: begin
                    // ready wins over the timeout on the same tick
                    if (i_pressure_ready) begin
                        go    = 1'b1;
                        go_to = PH_ADSORB;
                    end else if (elapsed >= r_press_timeout) begin
                        go    = 1'b1;
                        go_to = PH_FAULT;
                    end
                end
                PH_ADSORB: begin
                    if (r_pend) begin
                        n_valves = (r_valves | V3) & ~(V4 | V6);
                        n_pumps  = r_pumps | P2 | P3;
                        n_pend   = 1'b0;
                    end
                    if (elapsed >= r_adsorb_time) begin
                        go    = 1'b1;
                        go_to = PH_RD_OUT;
                    end
                end
                PH_RD_OUT: begin
                    go    = 1'b1;
                    go_to = PH_CLEAN;
                end
                PH_CLEAN: begin
                    if (r_pend) begin
                        n_valves = (r_valves & ~(V3 | V2)) | V6;
                        n_pumps  = r_pumps | P2 | P3;
                        n_pend   = 1'b0;
                    end
                    if (elapsed >= r_clean_time) begin
                        go    = 1'b1;
                        go_to = PH_DONE;
                    end
                end
                PH_DONE: begin
                    n_valves = r_valves & ~(V3 | V6);
                    n_pumps  = r_pumps & ~(P2 | P3);
                    go       = 1'b1;
                    go_to    = PH_PRESS;
                end
                PH_FAULT: begin
                    // hold here until a restart word
                    if (r_pend) begin
                        n_valves = '0;
                        n_pumps  = '0;
                        n_pend   = 1'b0;
                    end
                end
                default: begin
                    // init and unused codes
                    n_valves = '0;
                    n_pumps  = '0;
                    go       = 1'b1;
                    go_to    = PH_PRESS;
                end
            endcase
        end
        n_phase   = go_to;
        n_start   = go ? i_now_ms : r_start;
        if (go) begin
            n_pend = 1'b1;
        end
        n_changed = go;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_timeout <= PRESS_TIMEOUT_RST;
            r_adsorb_time   <= ADSORB_TIME_RST;
            r_clean_time    <= CLEAN_TIME_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_PRESS_TIMEOUT: r_press_timeout <= i_cfg_data;
                REG_ADSORB_TIME:   r_adsorb_time   <= i_cfg_data;
                REG_CLEAN_TIME:    r_clean_time    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_INIT;
            r_start  <= '0;
            r_pend   <= 1'b1;
            r_valves <= '0;
            r_pumps  <= '0;
        end else if (in_acc) begin
            r_phase  <= n_phase;
            r_start  <= n_start;
            r_pend   <= n_pend;
            r_valves <= n_valves;
            r_pumps  <= n_pumps;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_o_state   <= n_phase;
            r_o_valves  <= n_valves;
            r_o_pumps   <= n_pumps;
            r_o_fault   <= (n_phase == PH_FAULT);
            r_o_changed <= n_changed;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_state_code    = r_o_state;
    assign o_valves_open   = r_o_valves;
    assign o_pumps_on      = r_o_pumps;
    assign o_in_fault      = r_o_fault;
    assign o_state_changed = r_o_changed;

endmodule
`default_nettype wire

// ===== src/acs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acs_checker
// Port-level checks for the adsorption cycle sequencer, bound to the top.
// ----------------------------------------------------------------------------
module acs_checker
#(
    parameter int NUM_VALVES = acs_pkg::NumValvesDef,
    parameter int NUM_PUMPS  = acs_pkg::NumPumpsDef
) (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   o_out_valid,
    input wire                   i_out_ready,
    input wire [3:0]             o_state_code,
    input wire [NUM_VALVES-1:0]  o_valves_open,
    input wire [NUM_PUMPS-1:0]   o_pumps_on,
    input wire                   o_in_fault,
    input wire                   o_state_changed
);
    import acs_pkg::*;

    // a waiting result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_state_code)
            && $stable(o_valves_open) && $stable(o_pumps_on)
            && $stable(o_in_fault) && $stable(o_state_changed))
        else $error("result word dropped or changed while stalled");

    a_fault_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_in_fault == (o_state_code == PH_FAULT)))
        else $error("fault flag disagrees with state code");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_state_code <= PH_FAULT))
        else $error("state code out of range");

    // read inlet lasts one word and always follows pressurize entry
    a_rd_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_state_code == PH_RD_IN) |-> o_state_changed && o_pumps_on[0])
        else $error("read inlet without transition or pump 1");

    a_rd_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_state_code == PH_RD_OUT) |-> o_state_changed)
        else $error("read outlet reported without transition");

endmodule

bind adsorption_cycle_sequencer acs_checker #(
    .NUM_VALVES (NUM_VALVES),
    .NUM_PUMPS  (NUM_PUMPS)
) u_acs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_state_code    (o_state_code),
    .o_valves_open   (o_valves_open),
    .o_pumps_on      (o_pumps_on),
    .o_in_fault      (o_in_fault),
    .o_state_changed (o_state_changed)
);
`default_nettype wire

// ===== bench/adsorption_cycle_sequencer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsorption_cycle_sequencer_checker
// Watches the sequencer channels, predicts each status word and compares.
// ----------------------------------------------------------------------------
// Keeps its own copy of the timer registers and of the cycle state. Every
// accepted input word advances the local sequencer and queues the status it
// should produce; every accepted output word is matched against the oldest
// queued status. The failure count and the number of words still awaited
// go back to the bench top.
// ----------------------------------------------------------------------------
module adsorption_cycle_sequencer_checker
(
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_valid,
    input  wire                               i_cfg_ready,
    input  wire  acs_pkg::t_cfg_idx           i_cfg_index,
    input  wire  acs_pkg::t_time              i_cfg_data,
    input  wire                               i_in_valid,
    input  wire                               i_in_ready,
    input  wire                               i_action,
    input  wire  acs_pkg::t_time              i_now_ms,
    input  wire                               i_pressure_ready,
    input  wire                               i_out_valid,
    input  wire                               i_out_ready,
    input  wire  [3:0]                        i_state_code,
    input  wire  [acs_pkg::NumValvesDef-1:0]  i_valves_open,
    input  wire  [acs_pkg::NumPumpsDef-1:0]   i_pumps_on,
    input  wire                               i_in_fault,
    input  wire                               i_state_changed,
    output int                                o_fail_count,
    output int                                o_pending
);
    import acs_pkg::*;

    localparam int MaxReports = 10;

    localparam logic [NumValvesDef-1:0] VALVE2 = NumValvesDef'(1) << 1;
    localparam logic [NumValvesDef-1:0] VALVE3 = NumValvesDef'(1) << 2;
    localparam logic [NumValvesDef-1:0] VALVE4 = NumValvesDef'(1) << 3;
    localparam logic [NumValvesDef-1:0] VALVE6 = NumValvesDef'(1) << 5;
    localparam logic [NumPumpsDef-1:0]  PUMP1  = NumPumpsDef'(1);
    localparam logic [NumPumpsDef-1:0]  PUMP2  = NumPumpsDef'(1) << 1;
    localparam logic [NumPumpsDef-1:0]  PUMP3  = NumPumpsDef'(1) << 2;

    typedef struct packed {
        t_phase                   state;
        logic [NumValvesDef-1:0]  valves;
        logic [NumPumpsDef-1:0]   pumps;
        logic                     fault;
        logic                     changed;
    } t_status;

    // local copy of the timer registers
    t_time timeout_ms;
    t_time adsorb_ms;
    t_time clean_ms;

    // local copy of the sequencer state
    t_phase                   cur_phase;
    t_time                    mark_ms;
    logic                     entry_due;
    logic [NumValvesDef-1:0]  valve_q;
    logic [NumPumpsDef-1:0]   pump_q;
    logic                     moved;

    t_status predicted_status_q[$];
    t_status observed;
    t_status awaited;
    t_status upcoming;
    int      fail_total = 0;

    task automatic clear_sequencer();
        timeout_ms = PRESS_TIMEOUT_RST;
        adsorb_ms  = ADSORB_TIME_RST;
        clean_ms   = CLEAN_TIME_RST;
        cur_phase  = PH_INIT;
        mark_ms    = '0;
        entry_due  = 1'b1;
        valve_q    = '0;
        pump_q     = '0;
    endtask

    task automatic enter_phase(input t_phase next, input t_time now);
        cur_phase = next;
        mark_ms   = now;
        entry_due = 1'b1;
        moved     = 1'b1;
    endtask

    task automatic advance_sequencer(input logic act, input t_time now, input logic rdy,
                                     output t_status res);
        t_time elapsed;
        elapsed = now - mark_ms;
        moved   = 1'b0;
        if (act == ACT_RESTART) begin
            // restart leaves valves and pumps where they are
            enter_phase(PH_INIT, now);
        end else begin
            case (cur_phase)
                PH_PRESS: begin
                    if (entry_due) begin
                        valve_q   = '0;
                        pump_q    = pump_q | PUMP1;
                        entry_due = 1'b0;
                    end
                    enter_phase(PH_RD_IN, now);
                end
                PH_RD_IN: begin
                    enter_phase(PH_CHECK, now);
                end
                PH_CHECK: begin
                    // pressure ready takes priority over the timeout
                    if (rdy) begin
                        enter_phase(PH_ADSORB, now);
                    end else if (elapsed >= timeout_ms) begin
                        enter_phase(PH_FAULT, now);
                    end
                end
                PH_ADSORB: begin
                    if (entry_due) begin
                        valve_q   = (valve_q | VALVE3) & ~(VALVE4 | VALVE6);
                        pump_q    = pump_q | PUMP2 | PUMP3;
                        entry_due = 1'b0;
                    end
                    if (elapsed >= adsorb_ms) begin
                        enter_phase(PH_RD_OUT, now);
                    end
                end
                PH_RD_OUT: begin
                    enter_phase(PH_CLEAN, now);
                end
                PH_CLEAN: begin
                    if (entry_due) begin
                        valve_q   = (valve_q & ~(VALVE3 | VALVE2)) | VALVE6;
                        pump_q    = pump_q | PUMP2 | PUMP3;
                        entry_due = 1'b0;
                    end
                    if (elapsed >= clean_ms) begin
                        enter_phase(PH_DONE, now);
                    end
                end
                PH_DONE: begin
                    valve_q = valve_q & ~(VALVE3 | VALVE6);
                    pump_q  = pump_q & ~(PUMP2 | PUMP3);
                    enter_phase(PH_PRESS, now);
                end
                PH_FAULT: begin
                    if (entry_due) begin
                        valve_q   = '0;
                        pump_q    = '0;
                        entry_due = 1'b0;
                    end
                end
                default: begin
                    valve_q = '0;
                    pump_q  = '0;
                    enter_phase(PH_PRESS, now);
                end
            endcase
        end
        res.state   = cur_phase;
        res.valves  = valve_q;
        res.pumps   = pump_q;
        res.fault   = (cur_phase == PH_FAULT);
        res.changed = moved;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_sequencer();
            predicted_status_q.delete();
            fail_total = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_PRESS_TIMEOUT: timeout_ms = i_cfg_data;
                    REG_ADSORB_TIME:   adsorb_ms  = i_cfg_data;
                    REG_CLEAN_TIME:    clean_ms   = i_cfg_data;
                    default: ;
                endcase
            end
            // match the output word before queueing the new input word
            if (i_out_valid && i_out_ready) begin
                observed = '{i_state_code, i_valves_open, i_pumps_on, i_in_fault,
                             i_state_changed};
                if (predicted_status_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= MaxReports) begin
                        $display("unexpected status word: state %0d valves %b pumps %b",
                                 observed.state, observed.valves, observed.pumps);
                    end
                end else begin
                    awaited = predicted_status_q.pop_front();
                    if (observed.state !== awaited.state ||
                        observed.valves !== awaited.valves ||
                        observed.pumps !== awaited.pumps ||
                        observed.fault !== awaited.fault ||
                        observed.changed !== awaited.changed) begin
                        fail_total++;
                        if (fail_total <= MaxReports) begin
                            $display({"status mismatch at %0t: expected state %0d valves %b ",
                                      "pumps %b fault %b changed %b, got state %0d valves %b ",
                                      "pumps %b fault %b changed %b"}, $realtime,
                                     awaited.state, awaited.valves, awaited.pumps,
                                     awaited.fault, awaited.changed,
                                     observed.state, observed.valves, observed.pumps,
                                     observed.fault, observed.changed);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                advance_sequencer(i_action, i_now_ms, i_pressure_ready, upcoming);
                predicted_status_q.push_back(upcoming);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= predicted_status_q.size();
    end

endmodule

// ===== bench/adsorption_cycle_sequencer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsorption_cycle_sequencer_tb
// Stimulus and verdict for the adsorption cycle sequencer.
// ----------------------------------------------------------------------------
// Runs a short directed walk through the full cycle, the pressure timeout
// with a wrapping timestamp and the restart paths, then random tick streams
// under several timer settings and three sender/receiver stall profiles.
// The checker beside the block predicts and compares every status word.
// ----------------------------------------------------------------------------
module adsorption_cycle_sequencer_tb;
    import acs_pkg::*;

    localparam t_cfg_idx REG_SPARE    = 2'd3;
    localparam t_time    TIME_MAX     = 32'hFFFF_FFFF;
    localparam int       SegmentWords = 155;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    t_cfg_idx  cfg_index = '0;
    t_time     cfg_data  = '0;

    logic      in_valid       = 1'b0;
    logic      in_ready;
    logic      action         = ACT_TICK;
    t_time     now_ms         = '0;
    logic      pressure_ready = 1'b0;

    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [3:0]               state_code;
    logic [NumValvesDef-1:0]  valves_open;
    logic [NumPumpsDef-1:0]   pumps_on;
    logic                     in_fault;
    logic                     state_changed;

    int    fail_count;
    int    pending;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    t_time clock_ms      = '0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    adsorption_cycle_sequencer dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_action         (action),
        .i_now_ms         (now_ms),
        .i_pressure_ready (pressure_ready),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_state_code     (state_code),
        .o_valves_open    (valves_open),
        .o_pumps_on       (pumps_on),
        .o_in_fault       (in_fault),
        .o_state_changed  (state_changed)
    );

    adsorption_cycle_sequencer_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_action         (action),
        .i_now_ms         (now_ms),
        .i_pressure_ready (pressure_ready),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_state_code     (state_code),
        .i_valves_open    (valves_open),
        .i_pumps_on       (pumps_on),
        .i_in_fault       (in_fault),
        .i_state_changed  (state_changed),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_word(input logic act, input t_time now, input logic rdy);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        action         <= act;
        now_ms         <= now;
        pressure_ready <= rdy;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_time data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic program_timers(input t_time timeout, input t_time adsorb,
                                  input t_time clean);
        write_reg(REG_PRESS_TIMEOUT, timeout);
        write_reg(REG_ADSORB_TIME, adsorb);
        write_reg(REG_CLEAN_TIME, clean);
        write_reg(REG_SPARE, $urandom());
        cfg_valid <= 1'b0;
    endtask

    // drop valid and hold until every queued status word has come back
    task automatic settle_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic run_traffic(input int count, input int span);
        int   roll;
        logic act;
        logic rdy;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            if (roll < 50) begin
                clock_ms += $urandom_range(span);
            end else if (roll < 70) begin
                clock_ms += $urandom_range(3 * span, span);
            end else if (roll < 80) begin
                // step back one millisecond: elapsed drops by one and wraps to its maximum if it was zero
                clock_ms += TIME_MAX;
            end else if (roll < 94) begin
                clock_ms += $urandom();
            end else begin
                clock_ms = $urandom();
            end
            act = ($urandom_range(99) < 5) ? ACT_RESTART : ACT_TICK;
            rdy = ($urandom_range(99) < 25);
            send_word(act, clock_ms, rdy);
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 22;
        recv_idle_pct = 63;

        // full cycle with the reset timer values
        send_word(ACT_TICK, 32'd0, 1'b0);
        send_word(ACT_TICK, 32'd1, 1'b0);
        send_word(ACT_TICK, 32'd2, 1'b0);
        send_word(ACT_TICK, 32'd1000, 1'b0);
        send_word(ACT_TICK, 32'd600002, 1'b1);
        send_word(ACT_TICK, 32'd600003, 1'b0);
        send_word(ACT_TICK, 32'd660002, 1'b0);
        send_word(ACT_TICK, 32'd660003, 1'b1);
        send_word(ACT_TICK, 32'd700000, 1'b0);
        send_word(ACT_TICK, 32'd780003, 1'b0);
        send_word(ACT_TICK, 32'd780004, 1'b0);
        send_word(ACT_RESTART, 32'd780005, 1'b1);
        send_word(ACT_RESTART, 32'd780006, 1'b0);

        // pressure timeout across the timestamp wrap, then fault and restart
        settle_results();
        program_timers(32'd100, '0, '0);
        send_word(ACT_TICK, 32'hFFFF_FF00, 1'b0);
        send_word(ACT_TICK, 32'hFFFF_FF01, 1'b0);
        send_word(ACT_TICK, 32'hFFFF_FFF0, 1'b0);
        send_word(ACT_TICK, 32'h0000_0050, 1'b0);
        send_word(ACT_TICK, 32'h0000_0054, 1'b0);
        send_word(ACT_TICK, 32'h0000_0055, 1'b1);
        send_word(ACT_RESTART, TIME_MAX, 1'b1);
        clock_ms = TIME_MAX;

        settle_results();
        program_timers($urandom_range(40), $urandom_range(40), $urandom_range(40));
        run_traffic(SegmentWords, 15);

        settle_results();
        program_timers('0, '0, '0);
        run_traffic(SegmentWords, 10);

        send_idle_pct = 63;
        recv_idle_pct = 22;
        settle_results();
        program_timers(TIME_MAX, $urandom_range(60), $urandom_range(60));
        run_traffic(SegmentWords, 20);

        settle_results();
        program_timers($urandom_range(40), $urandom_range(40), $urandom_range(40));
        run_traffic(SegmentWords, 15);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        settle_results();
        program_timers($urandom_range(30), TIME_MAX, $urandom_range(30));
        run_traffic(SegmentWords, 15);

        settle_results();
        program_timers($urandom_range(40), $urandom_range(40), TIME_MAX);
        run_traffic(SegmentWords, 15);

        settle_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("adsorption_cycle_sequencer: match");
        end else begin
            $display("adsorption_cycle_sequencer: mismatch");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("adsorption_cycle_sequencer: mismatch");
        $finish;
    end

endmodule

// ===== adsorption_cycle_sequencer.f =====
src/acs_pkg.sv
src/adsorption_cycle_sequencer.sv
src/acs_checker.sv
bench/adsorption_cycle_sequencer_checker.sv
bench/adsorption_cycle_sequencer_tb.sv
